>>> sv/mtg_pkg.sv
// shared types and constants for the mersenne twister generator
package mtg_pkg;

    localparam int STATE_WORDS  = 624;
    localparam int TWIST_OFFSET = 397;
    localparam int ADDR_W       = $clog2(STATE_WORDS);
    localparam int POS_W        = 10;

    localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(STATE_WORDS - 1);
    localparam logic [POS_W-1:0]  POS_FULL    = POS_W'(STATE_WORDS);
    localparam logic [POS_W-1:0]  POS_UNSEEDED = POS_W'(STATE_WORDS + 1);

    localparam logic [31:0] SEED_MULT    = 32'd69069;
    localparam logic [31:0] DEFAULT_SEED = 32'd4357;
    localparam logic [31:0] MATRIX_A     = 32'h9908b0df;
    localparam logic [31:0] TEMPER_B     = 32'h9d2c5680;
    localparam logic [31:0] TEMPER_C     = 32'hefc60000;

    localparam logic OP_GENERATE = 1'b0;
    localparam logic OP_SEED     = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_TW_PRE,
        ST_TW_RD,
        ST_TW_WR,
        ST_GEN_RD,
        ST_GEN_OUT
    } mtg_state_t;

    typedef struct packed {
        logic seed_load;
        logic seed_default;
        logic seed_step;
        logic tw_start;
        logic tw_read;
        logic tw_write;
        logic gen_read;
        logic out_load;
    } mtg_cmd_t;

    typedef struct packed {
        logic cnt_last;
        logic pos_ge;
        logic pos_gt;
        logic out_busy;
    } mtg_status_t;

endpackage

>>> sv/mtg_ctrl.sv
// control state machine for seeding, twisting and word output
module mtg_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_op,
    output logic                in_ready,
    input  mtg_pkg::mtg_status_t st,
    output mtg_pkg::mtg_cmd_t    cmd
);
    import mtg_pkg::*;

    mtg_state_t state_reg, state_next;
    logic       gen_reg, gen_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            gen_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            gen_reg   <= gen_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        gen_next   = gen_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_op == OP_SEED)
                    begin
                        cmd.seed_load = 1'b1;
                        gen_next      = 1'b0;
                        state_next    = ST_SEED;
                    end
                    else if (st.pos_gt)
                    begin
                        cmd.seed_load    = 1'b1;
                        cmd.seed_default = 1'b1;
                        gen_next         = 1'b1;
                        state_next       = ST_SEED;
                    end
                    else if (st.pos_ge)
                    begin
                        state_next = ST_TW_PRE;
                    end
                    else
                    begin
                        state_next = ST_GEN_RD;
                    end
                end
            end
            ST_SEED:
            begin
                cmd.seed_step = 1'b1;
                if (st.cnt_last)
                begin
                    state_next = gen_reg ? ST_TW_PRE : ST_IDLE;
                end
            end
            ST_TW_PRE:
            begin
                cmd.tw_start = 1'b1;
                state_next   = ST_TW_RD;
            end
            ST_TW_RD:
            begin
                cmd.tw_read = 1'b1;
                state_next  = ST_TW_WR;
            end
            ST_TW_WR:
            begin
                cmd.tw_write = 1'b1;
                state_next   = st.cnt_last ? ST_GEN_RD : ST_TW_RD;
            end
            ST_GEN_RD:
            begin
                cmd.gen_read = 1'b1;
                state_next   = ST_GEN_OUT;
            end
            ST_GEN_OUT:
            begin
                if (!st.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> sv/mtg_datapath.sv
// state memory, seed recurrence, twist, tempering and output register
module mtg_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  mtg_pkg::mtg_cmd_t    cmd,
    output mtg_pkg::mtg_status_t st,
    input  logic [31:0]         seed_value,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [31:0]         out_word
);
    import mtg_pkg::*;

    logic [31:0]       mem [STATE_WORDS];
    logic [31:0]       rd1_q, rd2_q;
    logic [ADDR_W-1:0] rd1_addr, rd2_addr;
    logic              rd1_en, rd2_en;
    logic              wr_en;
    logic [31:0]       wr_data;

    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [31:0]       seed_reg, seed_next;
    logic [31:0]       cur_reg, cur_next;
    logic              valid_reg, valid_next;
    logic [31:0]       word_reg, word_next;

    logic [63:0]       seed_prod;
    logic [ADDR_W:0]   next_sum, far_sum;
    logic [ADDR_W-1:0] next_addr, far_addr;
    logic              cnt_last;
    logic [31:0]       twist_y, twist_v;

    function automatic logic [31:0] temper(input logic [31:0] x);
        logic [31:0] y;
        y = x;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    assign cnt_last  = (cnt_reg == LAST_ADDR);
    assign seed_prod = {32'd0, seed_reg} * {32'd0, SEED_MULT};

    // wrapped neighbor and far addresses
    assign next_sum  = {1'b0, cnt_reg} + (ADDR_W+1)'(1);
    assign far_sum   = {1'b0, cnt_reg} + (ADDR_W+1)'(TWIST_OFFSET);
    assign next_addr = (next_sum >= (ADDR_W+1)'(STATE_WORDS))
                       ? ADDR_W'(next_sum - (ADDR_W+1)'(STATE_WORDS)) : next_sum[ADDR_W-1:0];
    assign far_addr  = (far_sum >= (ADDR_W+1)'(STATE_WORDS))
                       ? ADDR_W'(far_sum - (ADDR_W+1)'(STATE_WORDS)) : far_sum[ADDR_W-1:0];

    assign twist_y = {cur_reg[31], rd1_q[30:0]};
    assign twist_v = rd2_q ^ (twist_y >> 1) ^ (twist_y[0] ? MATRIX_A : 32'd0);

    always_comb
    begin
        rd1_en   = cmd.tw_start | cmd.tw_read | cmd.gen_read;
        rd2_en   = cmd.tw_read;
        rd1_addr = '0;
        if (cmd.tw_read)
        begin
            rd1_addr = next_addr;
        end
        else if (cmd.gen_read)
        begin
            rd1_addr = pos_reg[ADDR_W-1:0];
        end
        rd2_addr = far_addr;
        wr_en    = cmd.seed_step | cmd.tw_write;
        wr_data  = cmd.tw_write ? twist_v : seed_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[cnt_reg] <= wr_data;
        end
        if (rd1_en)
        begin
            rd1_q <= mem[rd1_addr];
        end
        if (rd2_en)
        begin
            rd2_q <= mem[rd2_addr];
        end
    end

    always_comb
    begin
        cnt_next   = cnt_reg;
        pos_next   = pos_reg;
        seed_next  = seed_reg;
        cur_next   = cur_reg;
        word_next  = word_reg;
        valid_next = valid_reg;
        if (out_ready)
        begin
            valid_next = 1'b0;
        end
        if (cmd.seed_load)
        begin
            seed_next = cmd.seed_default ? DEFAULT_SEED : seed_value;
            cnt_next  = '0;
        end
        if (cmd.seed_step)
        begin
            seed_next = seed_prod[31:0];
            cnt_next  = cnt_last ? '0 : cnt_reg + ADDR_W'(1);
            if (cnt_last)
            begin
                pos_next = POS_FULL;
            end
        end
        if (cmd.tw_start)
        begin
            cnt_next = '0;
        end
        if (cmd.tw_read)
        begin
            cur_next = rd1_q;
        end
        if (cmd.tw_write)
        begin
            cur_next = rd1_q;
            cnt_next = cnt_last ? '0 : cnt_reg + ADDR_W'(1);
            if (cnt_last)
            begin
                pos_next = '0;
            end
        end
        if (cmd.out_load)
        begin
            word_next  = temper(rd1_q);
            valid_next = 1'b1;
            pos_next   = pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            pos_reg   <= POS_UNSEEDED;
            valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            pos_reg   <= pos_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seed_reg <= seed_next;
        cur_reg  <= cur_next;
        word_reg <= word_next;
    end

    assign st.cnt_last = cnt_last;
    assign st.pos_ge   = (pos_reg >= POS_FULL);
    assign st.pos_gt   = (pos_reg > POS_FULL);
    assign st.out_busy = valid_reg & ~out_ready;

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

>>> sv/mersenne_twister_generator.sv
// top level of the 32-bit mt19937 generator
//
// slave channel: one request per transfer; s_tuser selects seed (1) or
// generate (0), s_tdata carries the seed. master channel: one tempered word
// per generate request, none for a seed request.
// a seed request writes the 624 state words one per cycle; the block takes
// no new request until the last word is written.
// a generate request reads the state memory, then tempers the word into the
// output register when no twist is due; every 624th word first twists the
// state, reading neighbor and far word and then writing each word. the first
// generate after reset also seeds with 4357 before that twist.
// outside of twists a new request is taken only after the previous one has
// done the single read of the state memory plus the output load.
// after reset the block is unseeded and no output is pending.
// the result waits in an output register while m_tready is low; the next
// request is still taken, and only its own output load waits for room.
module mersenne_twister_generator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // seed_value
    input  logic [0:0]  s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // random_word
);
    import mtg_pkg::*;

    mtg_cmd_t    cmd;
    mtg_status_t st;

    mtg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_op    (s_tuser[0]),
        .in_ready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    mtg_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .st         (st),
        .seed_value (s_tdata),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_word   (m_tdata)
    );

endmodule
